// ----- rtl/core/linear_probe_hash_map_defines.svh -----
// assertion macros for the hash map checker
`ifndef LINEAR_PROBE_HASH_MAP_DEFINES_SVH
`define LINEAR_PROBE_HASH_MAP_DEFINES_SVH
// implication checked on every clock edge outside reset
`define LPHM_ASSERT_IMP(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
	else $error("assertion failed");
// next-cycle implication
`define LPHM_ASSERT_NXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
	else $error("assertion failed");
`endif

// ----- rtl/core/lphm_pkg.sv -----
`timescale 1ns / 1ps
package lphm_pkg;
	localparam logic [31:0] FNV_PRIME = 32'd16777619;
	localparam logic [31:0] FNV_BASIS = 32'd2166136261;
	localparam logic [1:0] MODE_INSERT = 2'd0;
	localparam logic [1:0] MODE_DELETE = 2'd1;

	// table size, a power of two so the home slot is the low hash bits
	// and the probe index wraps on its own width
	localparam int SLOTS = 64;

	// controller to datapath commands
	typedef struct packed {
		logic load;      // capture request
		logic hash_step; // one fnv byte
		logic set_home;  // probe index from hash
		logic rd;        // read slot at probe index
		logic adv;       // probe index plus one
		logic wr_new;    // write request into probe slot
		logic wr_val;    // update value at probe slot
		logic clr;       // clear used bit at gap
		logic mv;        // move probe slot to gap, gap moves
		logic gap_set;   // gap from probe index, slot freed
		logic cnt_inc;
		logic cnt_dec;
		logic res_hit;   // latch result found
		logic res_full;
	} lphm_cmd_t;

	// datapath status
	typedef struct packed {
		logic hash_done;
		logic used;      // registered read: slot used
		logic match;     // registered read: key match
		logic stays;     // moved entry's home lies in (gap, j]
		logic full;      // entry count at capacity
		logic wrapped;   // probe slot is the last unvisited one
	} lphm_sts_t;
endpackage

// ----- rtl/core/linear_probe_hash_map.sv -----
`timescale 1ns / 1ps
// Key-value table with open addressing and FNV-1 hashing.
// Input channel: in_valid / in_stall with mode, key_bytes, key_length,
// new_value. Output channel: out_valid / out_stall with found,
// result_value, status. One result for every request, in order.
// One request is worked on at a time; in_stall is high from acceptance
// until its result transfers.
// After acceptance the block hashes the key byte by byte, sets the home
// slot, then for each probed slot does a registered table read and then a
// compare; a delete reads and checks each slot walked in the backward
// shift, including the empty slot that ends it; then out_valid rises.
// A new key on a full table probes all 64 slots before it is refused.
// The probe length and the single table read port set the rate.
// Reset clears all used bits and the entry count at once, so the block
// accepts requests straight after reset.
// While out_stall is high the result holds and no request is taken.
// An insert into a full table with a new key returns status 1.
module linear_probe_hash_map #(
	parameter int KEY_BYTES = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  mode,
	input  logic [63:0] key_bytes,
	input  logic [3:0]  key_length,
	input  logic [31:0] new_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        found,
	output logic [31:0] result_value,
	output logic        status
);
	lphm_pkg::lphm_cmd_t cmd;
	lphm_pkg::lphm_sts_t sts;
	logic [1:0] mode_q;

	lphm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .mode(mode_q),
		.sts(sts), .cmd(cmd)
	);

	lphm_datapath #(.KEY_BYTES(KEY_BYTES)) u_dp (
		.clk(clk), .arst_n(arst_n), .in_mode(mode), .in_key(key_bytes),
		.in_len(key_length), .in_value(new_value), .cmd(cmd), .sts(sts),
		.mode_q(mode_q), .found_q(found), .rv_q(result_value), .status_q(status)
	);
endmodule

// ----- rtl/core/lphm_datapath.sv -----
`timescale 1ns / 1ps
module lphm_datapath #(
	parameter int KEY_BYTES = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [1:0]          in_mode,
	input  logic [63:0]         in_key,
	input  logic [3:0]          in_len,
	input  logic [31:0]         in_value,
	input  lphm_pkg::lphm_cmd_t cmd,
	output lphm_pkg::lphm_sts_t sts,
	output logic [1:0]          mode_q,
	output logic                found_q,
	output logic [31:0]         rv_q,
	output logic                status_q
);
	localparam int SLOTS = lphm_pkg::SLOTS;
	localparam int AW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS + 1);

	logic [SLOTS-1:0] used_q;
	logic [SLOTS-1:0] used_d;
	logic [63:0] mem_key [SLOTS];
	logic [3:0]  mem_len [SLOTS];
	logic [31:0] mem_val [SLOTS];
	logic [31:0] mem_hash [SLOTS];

	logic [63:0] key_q;
	logic [3:0]  len_q, bi_q;
	logic [31:0] nv_q, h_q;
	logic [AW-1:0] idx_q, gap_q;
	logic [CW-1:0] cnt_q, steps_q;
	logic [63:0] rk_q;
	logic [3:0]  rl_q;
	logic [31:0] rvl_q, rh_q;
	logic        ru_q;
	logic [AW-1:0] ridx_q;

	// saturated length and masked key
	logic [3:0] len_sat;
	logic [63:0] key_m;
	always_comb begin
		len_sat = (in_len > 4'(KEY_BYTES)) ? 4'(KEY_BYTES) : in_len;
		for (int b = 0; b < 8; b++)
			key_m[8*b +: 8] = (4'(b) < len_sat) ? in_key[8*b +: 8] : 8'h00;
	end

	// request capture, fnv step, probe index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bi_q <= '0;
			idx_q <= '0;
			steps_q <= '0;
			key_q <= '0;
			len_q <= '0;
			nv_q <= '0;
			mode_q <= '0;
			h_q <= '0;
			gap_q <= '0;
		end else begin
			if (cmd.load) begin
				bi_q <= '0;
				key_q <= key_m;
				len_q <= len_sat;
				nv_q <= in_value;
				mode_q <= in_mode;
				h_q <= lphm_pkg::FNV_BASIS;
			end else if (cmd.hash_step) begin
				h_q <= (h_q * lphm_pkg::FNV_PRIME) ^ {24'd0, key_q[{bi_q[2:0], 3'b000} +: 8]};
				bi_q <= bi_q + 4'd1;
			end
			if (cmd.set_home) begin
				idx_q <= h_q[AW-1:0];
				steps_q <= '0;
			end else if (cmd.adv) begin
				idx_q <= idx_q + AW'(1);
				steps_q <= steps_q + CW'(1);
			end
			if (cmd.gap_set) gap_q <= idx_q;
			else if (cmd.mv) gap_q <= ridx_q;
		end
	end

	// registered slot read and table writes
	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rk_q <= mem_key[idx_q];
			rl_q <= mem_len[idx_q];
			rvl_q <= mem_val[idx_q];
			rh_q <= mem_hash[idx_q];
			ridx_q <= idx_q;
		end
		if (cmd.wr_new) begin
			mem_key[idx_q] <= key_q;
			mem_len[idx_q] <= len_q;
			mem_hash[idx_q] <= h_q;
		end
		if (cmd.wr_new || cmd.wr_val) mem_val[idx_q] <= nv_q;
		if (cmd.mv) begin
			mem_key[gap_q] <= rk_q;
			mem_len[gap_q] <= rl_q;
			mem_val[gap_q] <= rvl_q;
			mem_hash[gap_q] <= rh_q;
		end
	end

	// next occupancy: insert sets, delete frees the hit slot, a move shifts the gap
	always_comb begin
		used_d = used_q;
		if (cmd.wr_new) used_d[idx_q] = 1'b1;
		if (cmd.gap_set) used_d[idx_q] = 1'b0;
		if (cmd.clr) used_d[gap_q] = 1'b0;
		if (cmd.mv) begin
			used_d[gap_q] = 1'b1;
			used_d[ridx_q] = 1'b0;
		end
	end

	// occupancy, count, result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			cnt_q <= '0;
			ru_q <= 1'b0;
			found_q <= 1'b0;
			rv_q <= '0;
			status_q <= 1'b0;
		end else begin
			if (cmd.rd) ru_q <= used_q[idx_q];
			used_q <= used_d;
			if (cmd.cnt_inc) cnt_q <= cnt_q + CW'(1);
			else if (cmd.cnt_dec && cnt_q != '0) cnt_q <= cnt_q - CW'(1);
			if (cmd.load) begin
				found_q <= 1'b0;
				rv_q <= '0;
				status_q <= 1'b0;
			end else if (cmd.res_hit) begin
				found_q <= 1'b1;
				rv_q <= rvl_q;
			end else if (cmd.res_full) status_q <= 1'b1;
		end
	end

	// status to controller
	logic [AW-1:0] home_r;
	always_comb begin
		home_r = rh_q[AW-1:0];
		sts.hash_done = (bi_q >= len_q);
		sts.used = ru_q;
		sts.match = ru_q && (rl_q == len_q) && (rk_q == key_q);
		if (gap_q <= ridx_q) sts.stays = (gap_q < home_r) && (home_r <= ridx_q);
		else sts.stays = (gap_q < home_r) || (home_r <= ridx_q);
		sts.full = (cnt_q >= CW'(SLOTS));
		sts.wrapped = (steps_q == CW'(SLOTS - 1));
	end
endmodule

// ----- rtl/core/lphm_ctrl.sv -----
`timescale 1ns / 1ps
module lphm_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	input  logic [1:0]          mode,
	input  lphm_pkg::lphm_sts_t sts,
	output lphm_pkg::lphm_cmd_t cmd
);
	typedef enum logic [3:0] {
		S_IDLE, S_HASH, S_HOME, S_READ, S_CHECK, S_DREAD, S_DCHECK, S_OUT
	} state_t;
	state_t state_q;

	assign in_stall = (state_q != S_IDLE);
	assign out_valid = (state_q == S_OUT);

	// command decode
	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE: cmd.load = in_valid;
			S_HASH: cmd.hash_step = !sts.hash_done;
			S_HOME: cmd.set_home = 1'b1;
			S_READ: cmd.rd = 1'b1;
			S_CHECK: begin
				if (!sts.used) begin
					if (mode == lphm_pkg::MODE_INSERT) begin
						cmd.wr_new = 1'b1;
						cmd.cnt_inc = 1'b1;
					end
				end else if (sts.match) begin
					cmd.res_hit = 1'b1;
					if (mode == lphm_pkg::MODE_INSERT) cmd.wr_val = 1'b1;
					else if (mode == lphm_pkg::MODE_DELETE) begin
						cmd.gap_set = 1'b1;
						cmd.cnt_dec = 1'b1;
						cmd.adv = 1'b1;
					end
				end else if (sts.wrapped) begin
					// every slot visited with no hit and no free slot
					if (mode == lphm_pkg::MODE_INSERT) cmd.res_full = sts.full;
				end else begin
					cmd.adv = 1'b1;
				end
			end
			S_DREAD: cmd.rd = 1'b1;
			S_DCHECK: begin
				if (!sts.used) cmd.clr = 1'b1;
				else if (sts.stays) cmd.adv = 1'b1;
				else begin
					cmd.mv = 1'b1;
					cmd.adv = 1'b1;
				end
			end
			S_OUT: ;
			default: ;
		endcase
	end

	// sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else begin
			unique case (state_q)
				S_IDLE: if (in_valid) state_q <= S_HASH;
				S_HASH: if (sts.hash_done) state_q <= S_HOME;
				S_HOME: state_q <= S_READ;
				S_READ: state_q <= S_CHECK;
				S_CHECK: begin
					if (!sts.used) state_q <= S_OUT;
					else if (sts.match) begin
						if (mode == lphm_pkg::MODE_DELETE) state_q <= S_DREAD;
						else state_q <= S_OUT;
					end else if (sts.wrapped) state_q <= S_OUT;
					else state_q <= S_READ;
				end
				S_DREAD: state_q <= S_DCHECK;
				S_DCHECK: begin
					if (!sts.used) state_q <= S_OUT;
					else state_q <= S_DREAD;
				end
				S_OUT: if (!out_stall) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ----- rtl/core/lphm_checker.sv -----
`timescale 1ns / 1ps
`include "linear_probe_hash_map_defines.svh"
module lphm_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic found,
	input logic [31:0] result_value,
	input logic status
);
	// no new request while a result waits
	`LPHM_ASSERT_IMP(a_busy, clk, arst_n, out_valid, in_stall)
	// a miss returns zero
	`LPHM_ASSERT_IMP(a_zero, clk, arst_n, out_valid && !found, result_value == 32'd0)
	// full status never with a hit
	`LPHM_ASSERT_IMP(a_full, clk, arst_n, out_valid && status, !found)
	// stalled result holds
	`LPHM_ASSERT_NXT(a_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(result_value))
endmodule

bind linear_probe_hash_map lphm_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .found(found),
	.result_value(result_value), .status(status)
);
